### rtl/pressure_temperature_compensation_macros.svh
// Assertion macros for the pressure/temperature compensation block.
// Used by the top level only; expects clk and rst_n in scope.
`ifndef PRESSURE_TEMPERATURE_COMPENSATION_MACROS_SVH
`define PRESSURE_TEMPERATURE_COMPENSATION_MACROS_SVH

// checked while out of reset
`define PTC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define PTC_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/ptc_pkg.sv
// Shared types and constants for the pressure/temperature compensation block.
// No dependencies.
package ptc_pkg;

  localparam int NUM_REGS   = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int DIV_W      = 64;

  localparam logic [CFG_IDX_W-1:0] REG_T1_T2 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_T3_P1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_P2_P3 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_P4_P5 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_P6_P7 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_P8_P9 = 3'd5;

  localparam logic signed [32:0] TF_OFFSET  = 33'sd128000;
  localparam logic [20:0]        P_FULL     = 21'd1048576;
  localparam logic signed [63:0] K_3125     = 64'sd3125;
  localparam logic signed [63:0] ONE_SH47   = 64'sh0000_8000_0000_0000;
  localparam logic signed [31:0] TC_MUL     = 32'sd5;
  localparam logic signed [31:0] TC_RND     = 32'sd128;

  typedef struct packed {
    logic [19:0] raw_temperature;
    logic [19:0] raw_pressure;
  } in_req_t;

  typedef struct packed {
    logic signed [26:0] temperature_centi;
    logic signed [31:0] fine_temperature;
    logic [31:0]        pressure_q24_8;
    logic               pressure_invalid;
  } out_rsp_t;

  typedef struct packed {
    logic [15:0]        t1;
    logic signed [15:0] t2;
    logic signed [15:0] t3;
    logic [15:0]        p1;
    logic signed [15:0] p2;
    logic signed [15:0] p3;
    logic signed [15:0] p4;
    logic signed [15:0] p5;
    logic signed [15:0] p6;
    logic signed [15:0] p7;
    logic signed [15:0] p8;
    logic signed [15:0] p9;
  } coef_t;

  // temperature stage -> pressure front end
  typedef struct packed {
    logic signed [26:0] tc;
    logic signed [31:0] tf;
    logic [19:0]        ap;
  } temp_res_t;

  // pressure front end -> divider
  typedef struct packed {
    logic signed [63:0] num;
    logic signed [63:0] den;
    logic signed [26:0] tc;
    logic signed [31:0] tf;
  } frac_t;

  // divider -> pressure back end
  typedef struct packed {
    logic signed [63:0] q;
    logic               invalid;
    logic signed [26:0] tc;
    logic signed [31:0] tf;
  } quot_t;

endpackage

### rtl/ptc_temp.sv
// Temperature compensation, five pipeline stages, 32-bit wrapping math.
// Depends on ptc_pkg.
module ptc_temp (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  ptc_pkg::coef_t      coef,
  input  logic                in_valid,
  input  ptc_pkg::in_req_t    in_data,
  output logic                out_valid,
  output ptc_pkg::temp_res_t  out_data
);

  localparam int NS = 5;

  logic [NS-1:0] v_r;
  logic signed [31:0] t2x, t3x;
  logic signed [31:0] a_r, b_r, m1_r, bb_r, tv1_r, m2_r, tf_r, tf5_r, tcm_r;
  logic signed [31:0] a_nxt, b_nxt, tc_sh;
  logic [19:0] ap1_r, ap2_r, ap3_r, ap4_r, ap5_r;

  assign t2x = 32'(coef.t2);
  assign t3x = 32'(coef.t3);

  assign a_nxt = $signed({15'b0, in_data.raw_temperature[19:3]})
               - $signed({15'b0, coef.t1, 1'b0});
  assign b_nxt = $signed({16'b0, in_data.raw_temperature[19:4]})
               - $signed({16'b0, coef.t1});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[NS-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_r   <= a_nxt;
      b_r   <= b_nxt;
      ap1_r <= in_data.raw_pressure;
      m1_r  <= a_r * t2x;
      bb_r  <= b_r * b_r;
      ap2_r <= ap1_r;
      tv1_r <= m1_r >>> 11;
      m2_r  <= (bb_r >>> 12) * t3x;
      ap3_r <= ap2_r;
      tf_r  <= tv1_r + (m2_r >>> 14);
      ap4_r <= ap3_r;
      tcm_r <= tf_r * ptc_pkg::TC_MUL + ptc_pkg::TC_RND;
      tf5_r <= tf_r;
      ap5_r <= ap4_r;
    end
  end

  assign tc_sh        = tcm_r >>> 8;
  assign out_valid    = v_r[NS-1];
  assign out_data.tc  = tc_sh[26:0];
  assign out_data.tf  = tf5_r;
  assign out_data.ap  = ap5_r;

endmodule

### rtl/ptc_pres_pre.sv
// Pressure front end: builds dividend and divisor, six pipeline stages.
// Depends on ptc_pkg.
module ptc_pres_pre (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  ptc_pkg::coef_t      coef,
  input  logic                in_valid,
  input  ptc_pkg::temp_res_t  in_data,
  output logic                out_valid,
  output ptc_pkg::frac_t      out_data
);

  localparam int NS = 6;

  logic [NS-1:0] v_r;
  ptc_pkg::temp_res_t d1_r, d2_r, d3_r, d4_r, d5_r, d6_r;

  logic signed [32:0] tfx, v1_r;
  logic signed [63:0] sqf;
  logic signed [63:0] p2x, p3x, p4x, p5x, p6x;
  logic signed [63:0] sq_r, m5_r, m2p_r, m5d_r, m2pd_r, m6_r, m3_r, v2_r, v1b_r;
  logic signed [63:0] dsum_r, pnum_r, prod_r, num_r;
  logic [20:0] pd;

  assign tfx = 33'(in_data.tf);
  assign p2x = 64'(coef.p2);
  assign p3x = 64'(coef.p3);
  assign p4x = 64'(coef.p4);
  assign p5x = 64'(coef.p5);
  assign p6x = 64'(coef.p6);
  assign sqf = 64'(v1_r) * 64'(v1_r);
  assign pd  = ptc_pkg::P_FULL - {1'b0, d4_r.ap};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[NS-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d1_r   <= in_data;
      v1_r   <= tfx - ptc_pkg::TF_OFFSET;
      d2_r   <= d1_r;
      sq_r   <= sqf;
      m5_r   <= 64'(v1_r) * p5x;
      m2p_r  <= 64'(v1_r) * p2x;
      d3_r   <= d2_r;
      m6_r   <= sq_r * p6x;
      m3_r   <= sq_r * p3x;
      m5d_r  <= m5_r;
      m2pd_r <= m2p_r;
      d4_r   <= d3_r;
      v2_r   <= m6_r + (m5d_r <<< 17) + (p4x <<< 35);
      v1b_r  <= (m3_r >>> 8) + (m2pd_r <<< 12);
      d5_r   <= d4_r;
      dsum_r <= ptc_pkg::ONE_SH47 + v1b_r;
      pnum_r <= ($signed({43'b0, pd}) <<< 31) - v2_r;
      d6_r   <= d5_r;
      prod_r <= dsum_r * $signed({48'b0, coef.p1});
      num_r  <= pnum_r * ptc_pkg::K_3125;
    end
  end

  assign out_valid    = v_r[NS-1];
  assign out_data.num = num_r;
  assign out_data.den = prod_r >>> 33;
  assign out_data.tc  = d6_r.tc;
  assign out_data.tf  = d6_r.tf;

endmodule

### rtl/ptc_div.sv
// Signed 64-bit divider, one quotient bit per stage, restoring form.
// Depends on ptc_pkg.
module ptc_div (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_valid,
  input  ptc_pkg::frac_t   in_data,
  output logic             out_valid,
  output ptc_pkg::quot_t   out_data
);

  localparam int W = ptc_pkg::DIV_W;

  logic [W:0] v_r, neg_r, inv_r;
  logic [W-1:0] rem_r [0:W];
  logic [W-1:0] nq_r  [0:W];
  logic [W-1:0] d_r   [0:W];
  logic signed [26:0] tc_r [0:W];
  logic signed [31:0] tf_r [0:W];

  logic [W-1:0] un, ud, q_mag;

  assign un = in_data.num[W-1] ? (W'(0) - in_data.num) : in_data.num;
  assign ud = in_data.den[W-1] ? (W'(0) - in_data.den) : in_data.den;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[W-1:0], in_valid};
    end
  end

  // operand prep: magnitudes, result sign, zero-divisor flag
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= '0;
      nq_r[0]  <= un;
      d_r[0]   <= ud;
      neg_r[0] <= in_data.num[W-1] ^ in_data.den[W-1];
      inv_r[0] <= (in_data.den == '0);
      tc_r[0]  <= in_data.tc;
      tf_r[0]  <= in_data.tf;
    end
  end

  for (genvar k = 1; k <= W; k++) begin : g_step
    logic [W:0] trial, diff;
    logic       ge;
    assign trial = {rem_r[k-1], nq_r[k-1][W-1]};
    assign diff  = trial - {1'b0, d_r[k-1]};
    assign ge    = (trial >= {1'b0, d_r[k-1]});
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= ge ? diff[W-1:0] : trial[W-1:0];
        nq_r[k]  <= {nq_r[k-1][W-2:0], ge};
        d_r[k]   <= d_r[k-1];
        neg_r[k] <= neg_r[k-1];
        inv_r[k] <= inv_r[k-1];
        tc_r[k]  <= tc_r[k-1];
        tf_r[k]  <= tf_r[k-1];
      end
    end
  end

  assign q_mag            = nq_r[W];
  assign out_valid        = v_r[W];
  assign out_data.q       = neg_r[W] ? $signed(W'(0) - q_mag) : $signed(q_mag);
  assign out_data.invalid = inv_r[W];
  assign out_data.tc      = tc_r[W];
  assign out_data.tf      = tf_r[W];

endmodule

### rtl/ptc_pres_post.sv
// Pressure back end: second-order correction, offset and saturation.
// Five pipeline stages. Depends on ptc_pkg.
module ptc_pres_post (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  ptc_pkg::coef_t    coef,
  input  logic              in_valid,
  input  ptc_pkg::quot_t    in_data,
  output logic              out_valid,
  output ptc_pkg::out_rsp_t out_data
);

  localparam int NS = 5;

  logic [NS-1:0] v_r;
  ptc_pkg::quot_t d1_r, d2_r, d3_r, d4_r;
  ptc_pkg::out_rsp_t res_r;

  logic signed [63:0] ps, p7x, p8x, p9x, pf;
  logic [63:0] ll_r, sq2_r;
  logic [31:0] hl_r;
  logic signed [63:0] w2f_r, w2_r, w2d_r, w1m_r, s_r;
  logic [31:0] psat;

  assign ps  = in_data.q >>> 13;
  assign p7x = 64'(coef.p7);
  assign p8x = 64'(coef.p8);
  assign p9x = 64'(coef.p9);
  assign pf  = (s_r >>> 8) + (p7x <<< 4);

  always_comb begin
    priority if (d4_r.invalid) begin
      psat = '0;
    end else if (pf[63]) begin
      psat = '0;
    end else if (pf[62:32] != '0) begin
      psat = '1;
    end else begin
      psat = pf[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[NS-2:0], in_valid};
    end
  end

  // ps*ps low 64 bits from 32-bit halves: lo*lo + 2*hi*lo << 32
  always_ff @(posedge clk) begin
    if (en) begin
      d1_r  <= in_data;
      ll_r  <= {32'b0, ps[31:0]} * {32'b0, ps[31:0]};
      hl_r  <= ps[63:32] * ps[31:0];
      w2f_r <= in_data.q * p8x;
      d2_r  <= d1_r;
      sq2_r <= ll_r + {hl_r[30:0], 33'b0};
      w2_r  <= w2f_r >>> 19;
      d3_r  <= d2_r;
      w1m_r <= $signed(sq2_r) * p9x;
      w2d_r <= w2_r;
      d4_r  <= d3_r;
      s_r   <= d3_r.q + (w1m_r >>> 25) + w2d_r;
      res_r.temperature_centi <= d4_r.tc;
      res_r.fine_temperature  <= d4_r.tf;
      res_r.pressure_q24_8    <= psat;
      res_r.pressure_invalid  <= d4_r.invalid;
    end
  end

  assign out_valid = v_r[NS-1];
  assign out_data  = res_r;

endmodule

### rtl/pressure_temperature_compensation.sv
// Top level: pressure/temperature compensation pipeline with config regs.
// Depends on ptc_pkg, ptc_temp, ptc_pres_pre, ptc_div, ptc_pres_post
// and pressure_temperature_compensation_macros.svh.
//
//   port group | dir | handshake          | payload
//   in_        | in  | in_valid/in_stall  | ptc_pkg::in_req_t
//   out_       | out | out_valid/out_stall| ptc_pkg::out_rsp_t
//   cfg_       | in  | cfg_we             | cfg_index, cfg_wdata
//
// One request per cycle sustained while the output is not stalled; the stages are
// 5 temperature + 6 pressure front end + 65 divider + 5 back end + output reg.
// The radix-2 divider sets the depth.
// rst_n is synchronous; it clears valid bits and the coefficient registers.
// A stalled output holds; the pipeline keeps moving until its last stage
// holds a request that cannot enter the output register.
`include "pressure_temperature_compensation_macros.svh"

module pressure_temperature_compensation (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  ptc_pkg::in_req_t                    in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output ptc_pkg::out_rsp_t                   out_data,
  input  logic                                cfg_we,
  input  logic [ptc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ptc_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  // coefficient registers, reset to zero
  logic [ptc_pkg::CFG_DATA_W-1:0] coeff_r [0:ptc_pkg::NUM_REGS-1];
  ptc_pkg::coef_t coef;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ptc_pkg::NUM_REGS; i++) begin
        coeff_r[i] <= '0;
      end
    end else if (cfg_we) begin
      unique case (cfg_index)
        ptc_pkg::REG_T1_T2: coeff_r[0] <= cfg_wdata;
        ptc_pkg::REG_T3_P1: coeff_r[1] <= cfg_wdata;
        ptc_pkg::REG_P2_P3: coeff_r[2] <= cfg_wdata;
        ptc_pkg::REG_P4_P5: coeff_r[3] <= cfg_wdata;
        ptc_pkg::REG_P6_P7: coeff_r[4] <= cfg_wdata;
        ptc_pkg::REG_P8_P9: coeff_r[5] <= cfg_wdata;
        default: ;  // unmapped index: write dropped
      endcase
    end
  end

  // unpack the twelve 16-bit coefficients
  assign coef.t1 = coeff_r[0][15:0];
  assign coef.t2 = coeff_r[0][31:16];
  assign coef.t3 = coeff_r[1][15:0];
  assign coef.p1 = coeff_r[1][31:16];
  assign coef.p2 = coeff_r[2][15:0];
  assign coef.p3 = coeff_r[2][31:16];
  assign coef.p4 = coeff_r[3][15:0];
  assign coef.p5 = coeff_r[3][31:16];
  assign coef.p6 = coeff_r[4][15:0];
  assign coef.p7 = coeff_r[4][31:16];
  assign coef.p8 = coeff_r[5][15:0];
  assign coef.p9 = coeff_r[5][31:16];

  // pipeline advance: the whole datapath moves together unless its last
  // stage is full and the output register cannot take it
  logic en, take;
  logic last_v;
  ptc_pkg::out_rsp_t last_d;

  logic               t_v, pre_v, div_v;
  ptc_pkg::temp_res_t t_d;
  ptc_pkg::frac_t     pre_d;
  ptc_pkg::quot_t     div_d;

  logic              out_v_r;
  ptc_pkg::out_rsp_t out_d_r;

  assign take     = !out_v_r || !out_stall;
  assign en       = take || !last_v;
  assign in_stall = !en;

  ptc_temp u_temp (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .coef      (coef),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .out_valid (t_v),
    .out_data  (t_d)
  );

  ptc_pres_pre u_pre (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .coef      (coef),
    .in_valid  (t_v),
    .in_data   (t_d),
    .out_valid (pre_v),
    .out_data  (pre_d)
  );

  ptc_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (pre_v),
    .in_data   (pre_d),
    .out_valid (div_v),
    .out_data  (div_d)
  );

  ptc_pres_post u_post (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .coef      (coef),
    .in_valid  (div_v),
    .in_data   (div_d),
    .out_valid (last_v),
    .out_data  (last_d)
  );

  // output register: takes the last stage whenever it is free or drained
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (take) begin
      out_v_r <= last_v;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_d_r <= last_d;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_d_r;

  // a flagged result never carries a pressure value
  `PTC_ASSERT(a_inv_zero, (out_valid && out_data.pressure_invalid) |-> (out_data.pressure_q24_8 == 32'd0), "flagged result has nonzero pressure")
  // input backpressure only comes from a held result
  `PTC_ASSERT(a_stall_src, in_stall |-> (out_valid && out_stall), "input stalled without held output")
  // reset empties the output register
  `PTC_ASSERT_RST(a_rst_empty, (!rst_n) |=> (!out_valid), "output valid right after reset")

endmodule

### dv/tb_pressure_temperature_compensation.sv
// Testbench for the pressure/temperature compensation pipeline.
// Holds its own predictor and compares each request's result field by field.
// Depends on ptc_pkg and pressure_temperature_compensation.
`timescale 1ns / 100ps

module tb_pressure_temperature_compensation;

  localparam int        DRAIN_CYCLES = 100;     // longer than the pipeline latency
  localparam int        CYCLE_LIMIT  = 600000;
  localparam longint    MIN64        = 64'sh8000_0000_0000_0000;
  localparam longint    MAX_U32      = 64'sd4294967295;

  logic                           clk;
  logic                           rst_n;
  logic                           in_valid;
  logic                           in_stall;
  ptc_pkg::in_req_t               in_data;
  logic                           out_valid;
  logic                           out_stall;
  ptc_pkg::out_rsp_t              out_data;
  logic                           cfg_we;
  logic [ptc_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [ptc_pkg::CFG_DATA_W-1:0] cfg_wdata;

  pressure_temperature_compensation uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Local copy of the calibration registers, updated as each write is issued.
  // Writes only happen while the pipeline is empty, so no request sees a mix.
  logic [31:0] coef_regs [ptc_pkg::NUM_REGS];

  ptc_pkg::in_req_t  pending_reqs [$];   // requests waiting for the driver
  ptc_pkg::out_rsp_t expected_rsps [$];  // predicted results, oldest first
  bit       hold_sender;        // sender pauses while set
  int       mismatches;
  int       cycle_count;

  always #5 clk = ~clk;

  // Compensation predictor: 32-bit wrapping temperature path, 64-bit wrapping
  // pressure path with one signed divide, saturation of the final pressure.
  function automatic ptc_pkg::out_rsp_t compensate(ptc_pkg::in_req_t req);
    ptc_pkg::out_rsp_t rsp;
    int       at, t1, t2, t3, a, b, tv1, tv2, tf, tcw;
    longint   p1, p2, p3, p4, p5, p6, p7, p8, p9;
    longint   v1, v2, p, num, ps, w1, w2;
    at  = {12'b0, req.raw_temperature};
    t1  = {16'b0, coef_regs[ptc_pkg::REG_T1_T2][15:0]};
    t2  = shortint'(coef_regs[ptc_pkg::REG_T1_T2][31:16]);
    t3  = shortint'(coef_regs[ptc_pkg::REG_T3_P1][15:0]);
    p1  = {48'b0, coef_regs[ptc_pkg::REG_T3_P1][31:16]};
    p2  = shortint'(coef_regs[ptc_pkg::REG_P2_P3][15:0]);
    p3  = shortint'(coef_regs[ptc_pkg::REG_P2_P3][31:16]);
    p4  = shortint'(coef_regs[ptc_pkg::REG_P4_P5][15:0]);
    p5  = shortint'(coef_regs[ptc_pkg::REG_P4_P5][31:16]);
    p6  = shortint'(coef_regs[ptc_pkg::REG_P6_P7][15:0]);
    p7  = shortint'(coef_regs[ptc_pkg::REG_P6_P7][31:16]);
    p8  = shortint'(coef_regs[ptc_pkg::REG_P8_P9][15:0]);
    p9  = shortint'(coef_regs[ptc_pkg::REG_P8_P9][31:16]);

    a   = (at >>> 3) - (t1 <<< 1);
    tv1 = (a * t2) >>> 11;
    b   = (at >>> 4) - t1;
    tv2 = (((b * b) >>> 12) * t3) >>> 14;
    tf  = tv1 + tv2;
    tcw = (tf * 5 + 128) >>> 8;

    rsp.temperature_centi = tcw[26:0];
    rsp.fine_temperature  = tf;
    rsp.pressure_q24_8    = '0;
    rsp.pressure_invalid  = 1'b0;

    v1 = longint'(tf) - 64'sd128000;
    v2 = v1 * v1 * p6;
    v2 = v2 + ((v1 * p5) <<< 17);
    v2 = v2 + (p4 <<< 35);
    v1 = ((v1 * v1 * p3) >>> 8) + ((v1 * p2) <<< 12);
    v1 = (((64'sd1 <<< 47) + v1) * p1) >>> 33;

    if (v1 == 0) begin
      // zero divisor: pressure forced to 0 and flagged
      rsp.pressure_invalid = 1'b1;
    end else begin
      p   = 64'sd1048576 - longint'({44'b0, req.raw_pressure});
      num = ((p <<< 31) - v2) * 64'sd3125;
      if (num == MIN64 && v1 == -64'sd1) begin
        p = num;                // the one overflowing quotient wraps
      end else begin
        p = num / v1;
      end
      ps = p >>> 13;
      w1 = (p9 * ps * ps) >>> 25;
      w2 = (p8 * p) >>> 19;
      p  = ((p + w1 + w2) >>> 8) + (p7 <<< 4);
      if (p < 0) begin
        rsp.pressure_q24_8 = '0;
      end else if (p > MAX_U32) begin
        rsp.pressure_q24_8 = '1;
      end else begin
        rsp.pressure_q24_8 = p[31:0];
      end
    end
    return rsp;
  endfunction

  task automatic report_mismatch(string field, longint exp_val, longint got_val);
    $display("[%0t] mismatch on %s: expected %0d, got %0d", $time, field, exp_val, got_val);
    mismatches++;
  endtask

  // Driver: bursts of requests separated by random gaps; a stalled request
  // holds its payload. Expectations are formed at the accepting edge.
  int burst_left;
  int gap_left;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid   <= 1'b0;
      burst_left <= 0;
      gap_left   <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_rsps.push_back(compensate(in_data));
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (pending_reqs.size() > 0 && !hold_sender) begin
          in_data  <= pending_reqs.pop_front();
          in_valid <= 1'b1;
          if (burst_left <= 1) begin
            // one burst in four runs with no gap after it
            burst_left <= $urandom_range(1, 40);
            gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 16);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: stall pattern switches among free-running, light and heavy.
  int stall_mode;
  int mode_left;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_mode <= 0;
      mode_left  <= 0;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= $urandom_range(0, 2);
        mode_left  <= $urandom_range(50, 300);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        default: out_stall <= ($urandom_range(0, 15) != 0);
      endcase
    end
  end

  // Monitor: each accepted result against the oldest prediction.
  always @(posedge clk) begin
    ptc_pkg::out_rsp_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_rsps.size() == 0) begin
        $display("[%0t] result with nothing expected", $time);
        mismatches++;
      end else begin
        want = expected_rsps.pop_front();
        if (out_data.temperature_centi !== want.temperature_centi)
          report_mismatch("temperature_centi", want.temperature_centi,
                          out_data.temperature_centi);
        if (out_data.fine_temperature !== want.fine_temperature)
          report_mismatch("fine_temperature", want.fine_temperature,
                          out_data.fine_temperature);
        if (out_data.pressure_q24_8 !== want.pressure_q24_8)
          report_mismatch("pressure_q24_8", want.pressure_q24_8, out_data.pressure_q24_8);
        if (out_data.pressure_invalid !== want.pressure_invalid)
          report_mismatch("pressure_invalid", want.pressure_invalid,
                          out_data.pressure_invalid);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic write_reg(logic [ptc_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    if (idx < ptc_pkg::NUM_REGS) coef_regs[idx] = val;   // out-of-range index is ignored
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Typical sensor calibration set
  task automatic load_typical();
    write_reg(ptc_pkg::REG_T1_T2, {16'sd26435, 16'd27504});
    write_reg(ptc_pkg::REG_T3_P1, {16'd36477, -16'sd1000});
    write_reg(ptc_pkg::REG_P2_P3, {16'sd3024, -16'sd10685});
    write_reg(ptc_pkg::REG_P4_P5, {16'sd140, 16'sd2855});
    write_reg(ptc_pkg::REG_P6_P7, {16'sd15500, -16'sd7});
    write_reg(ptc_pkg::REG_P8_P9, {16'sd6000, -16'sd14600});
  endtask

  task automatic load_all(logic [31:0] val);
    for (int i = 0; i < ptc_pkg::NUM_REGS; i++) write_reg(i[ptc_pkg::CFG_IDX_W-1:0], val);
  endtask

  task automatic load_random();
    for (int i = 0; i < ptc_pkg::NUM_REGS; i++) write_reg(i[ptc_pkg::CFG_IDX_W-1:0], $urandom);
  endtask

  function automatic ptc_pkg::in_req_t pick_request();
    ptc_pkg::in_req_t r;
    if ($urandom_range(0, 1) == 0) begin
      r.raw_temperature = 20'($urandom_range(0, 20'hFFFFF));
      r.raw_pressure    = 20'($urandom_range(0, 20'hFFFFF));
    end else begin
      // realistic conversions around room conditions
      r.raw_temperature = 20'($urandom_range(440000, 600000));
      r.raw_pressure    = 20'($urandom_range(250000, 600000));
    end
    return r;
  endfunction

  task automatic queue_random(int count);
    repeat (count) pending_reqs.push_back(pick_request());
  endtask

  task automatic queue_pair(logic [19:0] t, logic [19:0] pr);
    ptc_pkg::in_req_t r;
    r.raw_temperature = t;
    r.raw_pressure    = pr;
    pending_reqs.push_back(r);
  endtask

  // Wait until everything queued has come back, then let the pipe settle.
  task automatic drain();
    while (pending_reqs.size() > 0 || in_valid || expected_rsps.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    clk         = 1'b0;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    out_stall   = 1'b0;
    cfg_we      = 1'b0;
    cfg_index   = '0;
    cfg_wdata   = '0;
    hold_sender = 1'b0;
    mismatches  = 0;
    cycle_count = 0;
    for (int i = 0; i < ptc_pkg::NUM_REGS; i++) coef_regs[i] = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // After reset every coefficient is zero: all pressures flagged invalid
    queue_pair(20'h00000, 20'h00000);
    queue_pair(20'hFFFFF, 20'hFFFFF);
    queue_random(30);
    drain();

    // Typical calibration, directed corners first
    load_typical();
    queue_pair(20'h00000, 20'h00000);
    queue_pair(20'hFFFFF, 20'hFFFFF);
    queue_pair(20'h00000, 20'hFFFFF);
    queue_pair(20'hFFFFF, 20'h00000);
    queue_pair(20'hAAAAA, 20'h55555);
    queue_pair(20'h55555, 20'hAAAAA);
    queue_pair(20'd519888, 20'd415148);
    queue_pair(20'd519888, 20'd1);
    queue_pair(20'd440064, 20'd300000);
    queue_pair(20'd600000, 20'd600000);
    queue_pair(20'd27504 << 4, 20'd415148);   // raw equal to T1 reference
    queue_random(150);
    // sender holds off mid-stream until the pipe is empty
    hold_sender = 1'b1;
    while (in_valid || expected_rsps.size() > 0) @(posedge clk);
    hold_sender = 1'b0;
    queue_random(150);
    drain();

    // Writes to unused indexes must not disturb the calibration
    write_reg(3'd6, $urandom);
    write_reg(3'd7, $urandom);
    queue_random(60);
    drain();

    // Random calibration sets
    repeat (4) begin
      load_random();
      queue_random(250);
      drain();
    end

    // Extremes of the coefficients
    load_all(32'hFFFF_FFFF);
    queue_random(120);
    drain();
    load_all(32'h8000_8000);
    queue_random(120);
    drain();
    load_all(32'h7FFF_7FFF);
    queue_random(120);
    drain();
    load_all(32'h8000_7FFF);
    queue_random(80);
    drain();
    load_typical();
    queue_random(100);
    drain();

    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
